@@ rtl/ldt_pkg.sv @@
// Package with the shared types and constants of the leaf dedup table.
package ldt_pkg;

  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  // Per-kind counters are one bit wider than an index so that they can reach the limit.
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = INDEX_W + 1;

  typedef struct packed {
    logic        is_bar;
    logic [3:0]  leaf_len;
    logic [63:0] word;
  } leaf_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] leaf_index;
    logic               is_new;
    logic               table_full;
    logic [63:0]        leaf_hash;
  } leaf_out_t;

  // Search key broadcast to every cell; kind_width is is_bar over leaf_len.
  typedef struct packed {
    logic [63:0] hash;
    logic [4:0]  kind_width;
    logic [63:0] word;
  } ldt_key_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [INDEX_W-1:0] index;
  } ldt_token_t;

  // Insert command broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
  } ldt_write_t;

endpackage

@@ rtl/ldt_hash.sv @@
// Multi-cycle murmur3 64-bit finalizer built around one shared 32x32 multiplier.
module ldt_hash
  import ldt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] word,
  output logic        done,
  output logic [63:0] hash_value
);

  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [2:0]  cnt;
  logic        phase;
  logic        running;

  logic [63:0] mul_const;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] product;
  logic [63:0] mixed;

  assign mul_const = phase ? MIX_MUL_B : MIX_MUL_A;

  // The low 64 bits of a 64x64 product need only three 32x32 partial products.
  always_comb begin
    case (cnt)
      3'd0: begin
        op_a = x[31:0];
        op_b = mul_const[31:0];
      end
      3'd1: begin
        op_a = x[63:32];
        op_b = mul_const[31:0];
      end
      default: begin
        op_a = x[31:0];
        op_b = mul_const[63:32];
      end
    endcase
  end

  assign product = 64'(op_a) * 64'(op_b);
  assign mixed   = acc ^ (acc >> MIX_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= 3'd0;
      phase   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x       <= word ^ (word >> MIX_SHIFT);
        running <= 1'b1;
        phase   <= 1'b0;
        cnt     <= 3'd0;
      end else if (running) begin
        case (cnt)
          3'd0: begin
            prod <= product;
            acc  <= '0;
            cnt  <= 3'd1;
          end
          3'd1: begin
            prod <= product;
            acc  <= acc + prod;
            cnt  <= 3'd2;
          end
          3'd2: begin
            prod <= product;
            acc  <= acc + {prod[31:0], 32'b0};
            cnt  <= 3'd3;
          end
          3'd3: begin
            acc <= acc + {prod[31:0], 32'b0};
            cnt <= 3'd4;
          end
          default: begin
            cnt <= 3'd0;
            if (!phase) begin
              x     <= mixed;
              phase <= 1'b1;
            end else begin
              // A zero hash is never output: it is replaced by one.
              hash_value <= (mixed == 64'd0) ? 64'd1 : mixed;
              running    <= 1'b0;
              done       <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/ldt_cell.sv @@
// One table cell: holds one entry and forwards the search token to its neighbor.
module ldt_cell
  import ldt_pkg::*;
#(
  parameter int unsigned USED_W  = 9,
  parameter int unsigned CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  ldt_key_t          key,
  input  ldt_write_t        wr,
  input  logic [USED_W-1:0] used,
  input  ldt_token_t        tok_in,
  output ldt_token_t        tok_out
);

  localparam logic [USED_W-1:0] MyId = USED_W'(CELL_ID);

  ldt_key_t           entry_key;
  logic [INDEX_W-1:0] entry_index;
  logic               occupied;
  logic               match;

  // Entries are filled in order, so a cell holds data exactly when it sits below the fill count.
  assign occupied = used > MyId;
  assign match    = occupied && (entry_key == key);

  always_ff @(posedge clk) begin
    if (wr.en && used == MyId) begin
      entry_key   <= key;
      entry_index <= wr.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.hit   <= tok_in.hit | match;
    tok_out.index <= tok_in.hit ? tok_in.index : entry_index;
  end

endmodule

@@ rtl/leaf_dedup_table_core.sv @@
// Top level of the leaf dedup table: hash unit, row of entry cells and control.
//
// A transaction is accepted when start is high while busy is low; busy then stays high
// until the result has been produced, and one item is handled at a time. Transactions
// sent back to back each pass through these steps in order: the hash unit runs the two
// 64-bit multiplies of the finalizer as three 32x32 partial products each on one shared
// multiplier, the search token walks the chain of cells, one cell per clock, and the
// result is registered. The next transaction can be accepted at the end of the cycle in
// which the result is shown. The result appears on result for exactly one cycle with
// done high, in the cycle after the token leaves the last cell; the receiver cannot
// stall it and must capture it then. No clearing pass is needed after reset: cells are
// filled in order and a cell takes part in a search only when it lies below the fill
// count, which reset clears.
module leaf_dedup_table_core
  import ldt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  leaf_in_t  request,
  output logic      done,
  output leaf_out_t result
);

  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [USED_W-1:0] Full = USED_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    HASH,
    SEARCH
  } state_t;

  state_t             state;
  ldt_key_t           key;
  logic               launch;
  logic [USED_W-1:0]  used_entries;
  logic [COUNT_W-1:0] number_count;
  logic [COUNT_W-1:0] string_count;

  logic               hash_done;
  logic [63:0]        hash_value;
  ldt_token_t         tok [TABLE_DEPTH+1];
  ldt_token_t         tail;
  ldt_write_t         wr;
  logic [COUNT_W-1:0] kind_count;
  logic               no_room;
  logic               accept;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  ldt_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .word       (request.word),
    .done       (hash_done),
    .hash_value (hash_value)
  );

  // The token reaches the first cell together with the hash latched into the key.
  assign tok[0].valid = launch;
  assign tok[0].hit   = 1'b0;
  assign tok[0].index = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ldt_cell #(
      .USED_W  (USED_W),
      .CELL_ID (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .wr      (wr),
      .used    (used_entries),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail = tok[TABLE_DEPTH];

  // A miss inserts only if the table has a free cell and the kind has indices left.
  assign kind_count = key.kind_width[4] ? string_count : number_count;
  assign no_room    = (used_entries == Full) || kind_count[COUNT_W-1];

  assign wr.en    = (state == SEARCH) && tail.valid && !tail.hit && !no_room;
  assign wr.index = kind_count[INDEX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      launch       <= 1'b0;
      done         <= 1'b0;
      used_entries <= '0;
      number_count <= '0;
      string_count <= '0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            key.kind_width <= {request.is_bar, request.leaf_len};
            key.word       <= request.word;
            state          <= HASH;
          end
        end
        HASH: begin
          if (hash_done) begin
            key.hash <= hash_value;
            launch   <= 1'b1;
            state    <= SEARCH;
          end
        end
        SEARCH: begin
          if (tail.valid) begin
            done              <= 1'b1;
            result.leaf_hash  <= key.hash;
            state             <= IDLE;
            if (tail.hit) begin
              result.leaf_index <= tail.index;
              result.is_new     <= 1'b0;
              result.table_full <= 1'b0;
            end else if (no_room) begin
              result.leaf_index <= '0;
              result.is_new     <= 1'b0;
              result.table_full <= 1'b1;
            end else begin
              result.leaf_index <= kind_count[INDEX_W-1:0];
              result.is_new     <= 1'b1;
              result.table_full <= 1'b0;
              used_entries      <= used_entries + USED_W'(1);
              if (key.kind_width[4]) begin
                string_count <= string_count + COUNT_W'(1);
              end else begin
                number_count <= number_count + COUNT_W'(1);
              end
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
